// ===== hdl/tcnm_pkg.sv =====
// Shared types and constants for the tag code nearest-match decoder.
package tcnm_pkg;

	localparam int ACTION_W   = 1;
	localparam int INDEX_W    = 10;
	localparam int CODE_W     = 36;
	localparam int TAG_W      = 10;
	localparam int ROT_W      = 2;
	localparam int ROT_N      = 4;
	localparam int LIMIT_W    = 6;
	localparam int COUNT_W    = 11;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	localparam logic [ACTION_W-1:0] ACTION_LOAD   = 1'b0;
	localparam logic [ACTION_W-1:0] ACTION_DECODE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_HAMMING_LIMIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CODE_COUNT    = 1'b1;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [INDEX_W-1:0]  entry_index;
		logic [CODE_W-1:0]   code_bits;
	} cmd_word_t;

	typedef struct packed {
		logic             found;
		logic [TAG_W-1:0] tag_id;
		logic [ROT_W-1:0] rotation;
	} res_word_t;

endpackage

// ===== hdl/tcnm_dist.sv =====
// Two-stage Hamming distance unit: chunk popcounts, then chunk sum, for four rotations.
module tcnm_dist
	import tcnm_pkg::*;
#(
	parameter int NBITS = 36,
	parameter int AW    = 10,
	parameter int DW    = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             src_valid,
	input  logic [AW-1:0]    src_idx,
	input  logic [NBITS-1:0] src_code,
	input  logic [NBITS-1:0] grid [ROT_N],
	output logic             busy,
	output logic             dst_valid,
	output logic [AW-1:0]    dst_idx,
	output logic [DW-1:0]    dst_dist [ROT_N]
);

	localparam int NCH = (NBITS + 7) / 8;
	localparam int CHW = 4;

	logic [NCH*8-1:0] diff     [ROT_N];
	logic [CHW-1:0]   cnt_c    [ROT_N][NCH];
	logic [CHW-1:0]   cnt_s2   [ROT_N][NCH];
	logic             valid_s2;
	logic [AW-1:0]    idx_s2;
	logic [DW-1:0]    sum_c    [ROT_N];
	logic [DW-1:0]    dist_s3  [ROT_N];
	logic             valid_s3;
	logic [AW-1:0]    idx_s3;

	// per byte popcount, eight steps deep
	always_comb begin
		for (int r = 0; r < ROT_N; r++) begin
			diff[r] = (NCH*8)'(grid[r] ^ src_code);
			for (int c = 0; c < NCH; c++) begin
				cnt_c[r][c] = '0;
				for (int b = 0; b < 8; b++) begin
					cnt_c[r][c] = cnt_c[r][c] + CHW'(diff[r][c*8+b]);
				end
			end
		end
	end

	always_comb begin
		for (int r = 0; r < ROT_N; r++) begin
			sum_c[r] = '0;
			for (int c = 0; c < NCH; c++) begin
				sum_c[r] = sum_c[r] + DW'(cnt_s2[r][c]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= src_valid;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		cnt_s2  <= cnt_c;
		idx_s2  <= src_idx;
		dist_s3 <= sum_c;
		idx_s3  <= idx_s2;
	end

	assign busy      = valid_s2 || valid_s3;
	assign dst_valid = valid_s3;
	assign dst_idx   = idx_s3;
	assign dst_dist  = dist_s3;

`ifndef SYNTHESIS
	a_valid_chain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> $past(src_valid, 2))
		else $error("distance result without a table read two cycles earlier");
`endif

endmodule

// ===== hdl/tag_code_nearest_match_top.sv =====
// Top level of the tag code nearest-match decoder.
//
// Command channel (cmd_valid/cmd_ready/cmd_word) takes two kinds of word.
// A load word (action = load) writes code_bits into table slot entry_index
// and returns nothing; slots at or beyond TABLE_DEPTH are dropped.
// A decode word sweeps table entries 0 .. min(code_count, TABLE_DEPTH)-1, one
// per cycle, scoring all four quarter turns of the grid in parallel, and
// returns one result word on res_valid/res_ready/res_word.
// Sweep path: table read (s1), byte popcounts (s2), distance sum (s3),
// running best per rotation (accumulator). The memory read port sets the sweep
// rate. The result is registered once the last entry has left the pipeline and
// the output register is free; the block then returns to idle.
// Only one command is in work at a time; cmd_ready is high while idle.
// The result sits in an output register, so a load or a new decode is taken
// while the receiver has not yet taken the last result. If that register is
// still full when a sweep ends, the block holds the finished result in its
// accumulators until res_ready frees the register.
// Reset clears both configuration registers (limit 0, count 0) and all control
// state; table contents are undefined until loaded and no clearing pass runs.
// The user writes configuration (cfg_we/cfg_index/cfg_wdata) only while idle; unenforced.
module tag_code_nearest_match_top
	import tcnm_pkg::*;
#(
	parameter int SIDE        = 6,
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  cmd_word_t             cmd_word,
	output logic                  res_valid,
	input  logic                  res_ready,
	output res_word_t             res_word,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int NBITS = SIDE * SIDE;
	localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW    = $clog2(TABLE_DEPTH + 1);
	localparam int DW    = $clog2(NBITS + 1);
	localparam int BW    = (DW > LIMIT_W) ? DW : LIMIT_W;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t              state_q;
	logic [LIMIT_W-1:0]  limit_q;
	logic [COUNT_W-1:0]  count_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       cnt_eff;
	logic [AW-1:0]       addr_q;
	logic [AW-1:0]       waddr;
	logic [NBITS-1:0]    grid_q   [ROT_N];
	logic [NBITS-1:0]    rot_g    [ROT_N];

	logic [CODE_W-1:0]   code_mem [TABLE_DEPTH];
	logic [CODE_W-1:0]   rd_s1;
	logic [AW-1:0]       idx_s1;
	logic                valid_s1;

	logic                dist_busy;
	logic                dist_valid;
	logic [AW-1:0]       dist_idx;
	logic [DW-1:0]       rot_dist  [ROT_N];

	logic [BW-1:0]       best_q    [ROT_N];
	logic                hit_q     [ROT_N];
	logic [AW-1:0]       best_idx_q[ROT_N];

	logic                cmd_fire;
	logic                load_wr;
	logic                start;
	logic                pipe_empty;
	logic                res_free;
	logic                finish;
	logic                res_valid_q;
	res_word_t           res_word_q;
	res_word_t           res_next;

	function automatic logic [NBITS-1:0] to_grid(input logic [CODE_W-1:0] v);
		logic [NBITS+CODE_W-1:0] ext;
		ext = {NBITS'(0), v};
		return ext[NBITS-1:0];
	endfunction

	// bit (i,j) moves to (j, SIDE-1-i); pure wiring
	function automatic logic [NBITS-1:0] quarter_turn(input logic [NBITS-1:0] g);
		logic [NBITS-1:0] r;
		r = '0;
		for (int i = 0; i < SIDE; i++) begin
			for (int j = 0; j < SIDE; j++) begin
				r[NBITS-1-(j*SIDE+(SIDE-1-i))] = g[NBITS-1-(i*SIDE+j)];
			end
		end
		return r;
	endfunction

	// ---- configuration ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
			count_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HAMMING_LIMIT: limit_q <= cfg_wdata[LIMIT_W-1:0];
				REG_CODE_COUNT:    count_q <= cfg_wdata[COUNT_W-1:0];
			endcase
		end
	end

	// ---- command decode ----
	assign cmd_ready = (state_q == ST_IDLE);
	assign cmd_fire  = cmd_valid && cmd_ready;
	assign waddr     = AW'(cmd_word.entry_index);
	assign load_wr   = cmd_fire && (cmd_word.action == ACTION_LOAD)
		&& (int'(cmd_word.entry_index) < TABLE_DEPTH);
	assign start     = cmd_fire && (cmd_word.action == ACTION_DECODE);

	// count above the table depth searches the whole table
	always_comb begin
		if (int'(count_q) > TABLE_DEPTH) begin
			cnt_eff = CW'(TABLE_DEPTH);
		end else begin
			cnt_eff = CW'(count_q);
		end
	end

	always_comb begin
		rot_g[0] = to_grid(cmd_word.code_bits);
		for (int r = 1; r < ROT_N; r++) begin
			rot_g[r] = quarter_turn(rot_g[r-1]);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			grid_q <= rot_g;
		end
	end

	// ---- sequencer ----
	assign pipe_empty = !valid_s1 && !dist_busy && !dist_valid;
	assign res_free   = !res_valid_q || res_ready;
	assign finish     = (state_q == ST_DRAIN) && pipe_empty && res_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			addr_q  <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						cnt_q   <= cnt_eff;
						addr_q  <= '0;
						state_q <= (cnt_eff == '0) ? ST_DRAIN : ST_SCAN;
					end
				end
				ST_SCAN: begin
					addr_q <= addr_q + AW'(1);
					if (CW'(addr_q) + CW'(1) == cnt_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---- s1: table memory, registered read ----
	always_ff @(posedge clk) begin
		if (load_wr) begin
			code_mem[waddr] <= cmd_word.code_bits;
		end
		rd_s1  <= code_mem[addr_q];
		idx_s1 <= addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_SCAN);
		end
	end

	// ---- s2/s3: distances ----
	tcnm_dist #(
		.NBITS (NBITS),
		.AW    (AW),
		.DW    (DW)
	) u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (valid_s1),
		.src_idx   (idx_s1),
		.src_code  (to_grid(rd_s1)),
		.grid      (grid_q),
		.busy      (dist_busy),
		.dst_valid (dist_valid),
		.dst_idx   (dist_idx),
		.dst_dist  (rot_dist)
	);

	// ---- accumulator: strict less-than keeps the lowest index on a tie ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROT_N; r++) begin
				best_q[r]     <= '0;
				hit_q[r]      <= 1'b0;
				best_idx_q[r] <= '0;
			end
		end else if (start) begin
			for (int r = 0; r < ROT_N; r++) begin
				best_q[r]     <= BW'(limit_q);
				hit_q[r]      <= 1'b0;
				best_idx_q[r] <= '0;
			end
		end else if (dist_valid) begin
			for (int r = 0; r < ROT_N; r++) begin
				if (BW'(rot_dist[r]) < best_q[r]) begin
					best_q[r]     <= BW'(rot_dist[r]);
					hit_q[r]      <= 1'b1;
					best_idx_q[r] <= dist_idx;
				end
			end
		end
	end

	// first rotation with a hit wins
	always_comb begin
		res_next = '0;
		for (int r = ROT_N - 1; r >= 0; r--) begin
			if (hit_q[r]) begin
				res_next.found    = 1'b1;
				res_next.tag_id   = TAG_W'(best_idx_q[r]);
				res_next.rotation = ROT_W'(r);
			end
		end
	end

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (finish) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			res_word_q <= res_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

`ifndef SYNTHESIS
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!valid_s1 && !dist_busy && !dist_valid))
		else $error("sweep pipeline busy while idle");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (CW'(addr_q) < cnt_q))
		else $error("table address beyond searched count");

	a_result_from_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> ($past(state_q) == ST_DRAIN))
		else $error("result raised outside the end of a sweep");
`endif

endmodule
